@@ rtl/core/prime_factorizer_core_defines.svh @@
// ----------------------------------------------------------------------------
// prime factorizer assertion macros
// shared property wrappers for the core checks, clocked on clock, off in reset
// ----------------------------------------------------------------------------
`ifndef PRIME_FACTORIZER_CORE_DEFINES_SVH
`define PRIME_FACTORIZER_CORE_DEFINES_SVH

// same-cycle implication
`define PF_ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define PF_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/core/pfact_pkg.sv @@
// ----------------------------------------------------------------------------
// pfact_pkg
// widths, state encoding and divider interface types for the prime factorizer
// ----------------------------------------------------------------------------
`default_nettype none

package pfact_pkg;

   localparam int VALUE_BITS = 31;
   localparam int EXP_BITS   = 5;
   localparam int CNT_BITS   = $clog2(VALUE_BITS + 1);

   typedef enum logic [1:0] {
      S_IDLE,
      S_WAIT,
      S_DECIDE,
      S_TAIL
   } state_type;

   typedef struct packed {
      logic [VALUE_BITS-1:0] quot;
      logic [VALUE_BITS-1:0] rem;
   } div_result_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

`default_nettype wire

@@ rtl/core/pfact_div.sv @@
// ----------------------------------------------------------------------------
// pfact_div
// restoring divider, one quotient bit per cycle, VALUE_BITS steps per division
// ----------------------------------------------------------------------------
`default_nettype none

module pfact_div
   import pfact_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   input  wire logic [VALUE_BITS-1:0] dividend,
   input  wire logic [VALUE_BITS-1:0] divisor,
   output div_result_type             result,
   output div_status_type             status
);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [CNT_BITS-1:0]   cnt_ff, cnt_in;
   logic [VALUE_BITS-1:0] qsh_ff, qsh_in;
   logic [VALUE_BITS-1:0] rem_ff, rem_in;
   logic [VALUE_BITS-1:0] dsr_ff, dsr_in;
   logic [VALUE_BITS:0]   trial;
   logic [VALUE_BITS:0]   diff;
   logic                  fits;

   // shift the next dividend bit into the partial remainder
   assign trial = {rem_ff, qsh_ff[VALUE_BITS-1]};
   assign diff  = trial - {1'b0, dsr_ff};
   assign fits  = (trial >= {1'b0, dsr_ff});

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      qsh_in  = qsh_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_BITS'(VALUE_BITS);
         qsh_in  = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
      end else if (busy_ff) begin
         qsh_in = {qsh_ff[VALUE_BITS-2:0], fits};
         rem_in = fits ? diff[VALUE_BITS-1:0] : trial[VALUE_BITS-1:0];
         cnt_in = cnt_ff - CNT_BITS'(1);
         if (cnt_ff == CNT_BITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      qsh_ff <= qsh_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign result.quot = qsh_ff;
   assign result.rem  = rem_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule

`default_nettype wire

@@ rtl/core/prime_factorizer_core.sv @@
// ----------------------------------------------------------------------------
// prime_factorizer_core
// trial-division prime factorization with a bit-serial divider
// ----------------------------------------------------------------------------
// req channel: one beat carries req_value_in; req_stall is high while a value
//    is being factored, so one value is worked on at a time.
// rsp channel: one beat per distinct prime, ascending, with its exponent;
//    rsp_last marks the final beat of a value. an input of 1 gives (1, 1),
//    an input of 0 gives (0, 0), each as a single beat.
// each trial divisor (2, then odd numbers) and each further division by a
//    found prime costs one pass of the serial divider, one quotient bit per
//    cycle. inputs 0 and 1 skip the divider.
// results go out through a single output register; the search keeps running
//    while a beat waits and holds only when the next result is ready and the
//    register is still stalled.
// reset (synchronous, active high) drops the current value and any beat held
//    in the output register and returns to idle.
// ----------------------------------------------------------------------------
`default_nettype none

`include "prime_factorizer_core_defines.svh"

module prime_factorizer_core
   import pfact_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic [VALUE_BITS-1:0] req_value_in,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic [VALUE_BITS-1:0]      rsp_prime_factor,
   output logic [EXP_BITS-1:0]        rsp_exponent,
   output logic                       rsp_last
);

   state_type             state_ff, state_in;
   logic [VALUE_BITS-1:0] n_ff, n_in;
   logic [VALUE_BITS-1:0] d_ff, d_in;
   logic [EXP_BITS-1:0]   e_ff, e_in;
   logic                  extract_ff, extract_in;
   logic                  have_pend_ff, have_pend_in;
   logic [VALUE_BITS-1:0] pend_p_ff, pend_p_in;
   logic [EXP_BITS-1:0]   pend_e_ff, pend_e_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [VALUE_BITS-1:0] rsp_prime_factor_ff, rsp_prime_factor_in;
   logic [EXP_BITS-1:0]   rsp_exponent_ff, rsp_exponent_in;
   logic                  rsp_last_ff, rsp_last_in;

   logic                  out_free;
   logic                  emit;
   logic [VALUE_BITS-1:0] next_d;
   logic                  n_gt_one;
   logic                  div_start;
   div_result_type        div_res;
   div_status_type        div_stat;

   pfact_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (n_in),
      .divisor  (d_in),
      .result   (div_res),
      .status   (div_stat)
   );

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign next_d   = (d_ff == VALUE_BITS'(2)) ? VALUE_BITS'(3) : d_ff + VALUE_BITS'(2);
   assign n_gt_one = (n_ff > VALUE_BITS'(1));

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = (req_value_in > VALUE_BITS'(1)) ? S_WAIT : S_TAIL;
            end
         end
         S_WAIT: begin
            if (div_stat.done) begin
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            if (!extract_ff) begin
               state_in = (div_res.quot >= d_ff) ? S_WAIT : S_TAIL;
            end else if (div_res.rem == '0 || !have_pend_ff || out_free) begin
               state_in = S_WAIT;
            end
         end
         S_TAIL: begin
            if (out_free && !(n_gt_one && have_pend_ff)) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // datapath and result register loads
   always_comb begin
      n_in                = n_ff;
      d_in                = d_ff;
      e_in                = e_ff;
      extract_in          = extract_ff;
      have_pend_in        = have_pend_ff;
      pend_p_in           = pend_p_ff;
      pend_e_in           = pend_e_ff;
      div_start           = 1'b0;
      emit                = 1'b0;
      rsp_prime_factor_in = rsp_prime_factor_ff;
      rsp_exponent_in     = rsp_exponent_ff;
      rsp_last_in         = rsp_last_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               n_in         = req_value_in;
               d_in         = VALUE_BITS'(2);
               e_in         = '0;
               extract_in   = 1'b0;
               have_pend_in = 1'b0;
               div_start    = (req_value_in > VALUE_BITS'(1));
            end
         end
         S_WAIT: begin
         end
         S_DECIDE: begin
            if (!extract_ff) begin
               // candidate still within the square root of the remainder
               if (div_res.quot >= d_ff) begin
                  if (div_res.rem == '0) begin
                     n_in       = div_res.quot;
                     e_in       = EXP_BITS'(1);
                     extract_in = 1'b1;
                  end else begin
                     d_in = next_d;
                  end
                  div_start = 1'b1;
               end
            end else if (div_res.rem == '0) begin
               n_in      = div_res.quot;
               e_in      = e_ff + EXP_BITS'(1);
               div_start = 1'b1;
            end else if (!have_pend_ff || out_free) begin
               // prime fully divided out: previous one goes out, this one waits
               if (have_pend_ff) begin
                  emit                = 1'b1;
                  rsp_prime_factor_in = pend_p_ff;
                  rsp_exponent_in     = pend_e_ff;
                  rsp_last_in         = 1'b0;
               end
               pend_p_in    = d_ff;
               pend_e_in    = e_ff;
               have_pend_in = 1'b1;
               extract_in   = 1'b0;
               d_in         = next_d;
               div_start    = 1'b1;
            end
         end
         S_TAIL: begin
            if (out_free) begin
               emit = 1'b1;
               priority if (n_gt_one && have_pend_ff) begin
                  rsp_prime_factor_in = pend_p_ff;
                  rsp_exponent_in     = pend_e_ff;
                  rsp_last_in         = 1'b0;
                  have_pend_in        = 1'b0;
               end else if (n_gt_one) begin
                  rsp_prime_factor_in = n_ff;
                  rsp_exponent_in     = EXP_BITS'(1);
                  rsp_last_in         = 1'b1;
               end else if (have_pend_ff) begin
                  rsp_prime_factor_in = pend_p_ff;
                  rsp_exponent_in     = pend_e_ff;
                  rsp_last_in         = 1'b1;
               end else begin
                  // input of one or zero
                  rsp_prime_factor_in = n_ff;
                  rsp_exponent_in     = {{(EXP_BITS-1){1'b0}}, n_ff[0]};
                  rsp_last_in         = 1'b1;
               end
            end
         end
         default: begin
         end
      endcase
      rsp_valid_in = (rsp_valid_ff && rsp_stall) || emit;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         have_pend_ff <= 1'b0;
         extract_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         have_pend_ff <= have_pend_in;
         extract_ff   <= extract_in;
      end
      n_ff                <= n_in;
      d_ff                <= d_in;
      e_ff                <= e_in;
      pend_p_ff           <= pend_p_in;
      pend_e_ff           <= pend_e_in;
      rsp_prime_factor_ff <= rsp_prime_factor_in;
      rsp_exponent_ff     <= rsp_exponent_in;
      rsp_last_ff         <= rsp_last_in;
   end

   assign req_stall        = (state_ff != S_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_prime_factor = rsp_prime_factor_ff;
   assign rsp_exponent     = rsp_exponent_ff;
   assign rsp_last         = rsp_last_ff;

   `PF_ASSERT_IMPLY(a_start_when_free, div_start, !div_stat.busy, "divider restarted while busy")
   `PF_ASSERT_IMPLY(a_wait_has_div, state_ff == S_WAIT, div_stat.busy || div_stat.done, "waiting on idle divider")
   `PF_ASSERT_IMPLY(a_divisor_odd, state_ff == S_WAIT, d_ff == VALUE_BITS'(2) || d_ff[0], "even trial divisor above two")
   `PF_ASSERT_NEXT(a_emit_loads, emit, rsp_valid_ff, "result beat lost on load")

endmodule

`default_nettype wire

@@ bench/prime_factorizer_core_tb.sv @@
// ----------------------------------------------------------------------------
// prime_factorizer_core_tb
// drives integers into the factorizer and checks every factor beat against a
// trial-division predictor, with random gaps on the request side and random
// stalls on the response side
// ----------------------------------------------------------------------------

module prime_factorizer_core_tb;
   import pfact_pkg::*;

   localparam longint unsigned VALUE_LIMIT = 64'd1 << VALUE_BITS;

   typedef struct packed {
      logic [VALUE_BITS-1:0] prime;
      logic [EXP_BITS-1:0]   exponent;
      logic                  last;
   } factor_beat_type;

   // primes used to build cheap random values
   localparam int SMALL_PRIME_COUNT = 25;
   localparam int SMALL_PRIMES [SMALL_PRIME_COUNT] = '{
      2, 3, 5, 7, 11, 13, 17, 19, 23, 29, 31, 37, 41, 43, 47,
      53, 59, 61, 67, 71, 73, 79, 83, 89, 97
   };

   logic                  clock;
   logic                  reset        = 1'b1;
   logic                  req_valid    = 1'b0;
   logic                  req_stall;
   logic [VALUE_BITS-1:0] req_value_in = '0;
   logic                  rsp_valid;
   logic                  rsp_stall    = 1'b0;
   logic [VALUE_BITS-1:0] rsp_prime_factor;
   logic [EXP_BITS-1:0]   rsp_exponent;
   logic                  rsp_last;

   factor_beat_type pending_factors[$];
   int              mismatch_count = 0;
   bit              no_idle        = 1'b0;
   int              stall_left     = 0;

   prime_factorizer_core u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_value_in     (req_value_in),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_prime_factor (rsp_prime_factor),
      .rsp_exponent     (rsp_exponent),
      .rsp_last         (rsp_last)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // generous timeout for the whole run
   initial begin
      #(96_000_000);
      $display("prime_factorizer_core test failed");
      $finish;
   end

   function automatic int draw_wait();
      return no_idle ? 0 : $urandom_range(0, 10);
   endfunction

   task automatic report_mismatch(input string what, input longint unsigned got,
                                  input longint unsigned want);
      if (mismatch_count < 50)
         $display("mismatch: %s got %0d want %0d", what, got, want);
      mismatch_count++;
   endtask

   // trial division by 2 and then odd candidates, one beat per distinct prime
   task automatic factorize_value(input logic [VALUE_BITS-1:0] value);
      longint unsigned rest;
      longint unsigned divisor;
      int              mult;
      factor_beat_type beat;
      rest    = value;
      divisor = 2;
      if (value == 0) begin
         pending_factors.push_back('{prime: '0, exponent: '0, last: 1'b1});
      end else if (value == 1) begin
         pending_factors.push_back('{prime: VALUE_BITS'(1), exponent: EXP_BITS'(1),
                                     last: 1'b1});
      end else begin
         while (divisor * divisor <= rest) begin
            if (rest % divisor == 0) begin
               mult = 0;
               while (rest % divisor == 0) begin
                  rest = rest / divisor;
                  mult++;
               end
               pending_factors.push_back('{prime: divisor[VALUE_BITS-1:0],
                                           exponent: mult[EXP_BITS-1:0], last: 1'b0});
            end
            divisor = (divisor == 2) ? 3 : divisor + 2;
         end
         // whatever survives the loop is a prime of its own
         if (rest > 1)
            pending_factors.push_back('{prime: rest[VALUE_BITS-1:0],
                                        exponent: EXP_BITS'(1), last: 1'b0});
         beat = pending_factors.pop_back();
         beat.last = 1'b1;
         pending_factors.push_back(beat);
      end
   endtask

   // called at a rising edge; returns at the edge where the beat is taken
   task automatic send_value(input logic [VALUE_BITS-1:0] value);
      int gap;
      gap = draw_wait();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_value_in <= value;
      do @(posedge clock); while (req_stall);
      factorize_value(value);
   endtask

   // products of small primes keep the trial loop short
   function automatic logic [VALUE_BITS-1:0] random_value();
      longint unsigned value;
      longint unsigned extra;
      int              kind;
      int              picks;
      kind  = $urandom_range(0, 9);
      value = 1;
      if (kind == 0)
         return VALUE_BITS'($urandom_range(0, 4095));
      picks = $urandom_range(1, 12);
      repeat (picks) begin
         extra = SMALL_PRIMES[$urandom_range(0, SMALL_PRIME_COUNT - 1)];
         if (value * extra < VALUE_LIMIT)
            value = value * extra;
      end
      if (kind <= 4) begin
         extra = $urandom_range(2, 4095);
         if (value * extra < VALUE_LIMIT)
            value = value * extra;
      end
      if (kind == 9) begin
         while (value * 2 < VALUE_LIMIT)
            value = value * 2;
      end
      return value[VALUE_BITS-1:0];
   endfunction

   // response side: after each beat, hold stall for a drawn number of valid cycles
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_left = 0;
      end else if (rsp_valid && !rsp_stall) begin
         stall_left = draw_wait();
         rsp_stall  <= (stall_left != 0);
      end else if (rsp_valid && stall_left != 0) begin
         stall_left = stall_left - 1;
         rsp_stall  <= (stall_left != 0);
      end
   end

   always @(posedge clock) begin
      factor_beat_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_factors.size() == 0) begin
            report_mismatch("beat with nothing pending, factor", rsp_prime_factor, 0);
         end else begin
            want = pending_factors.pop_front();
            if (rsp_prime_factor !== want.prime)
               report_mismatch("prime factor", rsp_prime_factor, want.prime);
            if (rsp_exponent !== want.exponent)
               report_mismatch("exponent", rsp_exponent, want.exponent);
            if (rsp_last !== want.last)
               report_mismatch("last", rsp_last, want.last);
         end
      end
   end

   task automatic test_trivial_inputs();
      // zero is the (0, 0) beat, one is the (1, 1) beat
      send_value(31'd0);
      send_value(31'd1);
      send_value(31'd2);
      send_value(31'd3);
      send_value(31'd4);
   endtask

   task automatic test_field_extremes();
      send_value(31'h7FFF_FFFF);    // largest value, a prime
      send_value(31'h7FFF_FFFE);
      send_value(31'h4000_0000);    // exponent 30
      send_value(31'd1162261467);   // 3^19
      send_value(31'h5555_5555);
      send_value(31'h2AAA_AAAA);
   endtask

   task automatic test_factor_shapes();
      send_value(31'd223092870);    // first nine primes, longest run of beats
      send_value(31'd9699690);
      send_value(31'd49);           // square of a prime, nothing left after the loop
      send_value(31'd25);
      send_value(31'd360);
      send_value(31'd997);          // prime left over after the loop
      send_value(31'd1000003);
      send_value(31'd4094);         // 2 * 23 * 89, tail factor right after a found one
   endtask

   task automatic test_back_to_back();
      no_idle = 1'b1;
      send_value(31'd6);
      send_value(31'd1);
      send_value(31'd0);
      send_value(31'd30030);
      no_idle = 1'b0;
   endtask

   task automatic test_random_values();
      for (int i = 0; i < 100; i++) begin
         if (i % 20 == 0)
            no_idle = ($urandom_range(0, 3) == 0);
         send_value(random_value());
      end
      no_idle = 1'b0;
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_trivial_inputs();
      test_field_extremes();
      test_factor_shapes();
      test_back_to_back();
      test_random_values();
      req_valid <= 1'b0;
      while (pending_factors.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (mismatch_count == 0)
         $display("prime_factorizer_core test passed");
      else
         $display("prime_factorizer_core test failed");
      $finish;
   end

endmodule
